@@ design/xcc_pkg.sv @@
package xcc_pkg;

    // cipher geometry
    localparam int ROUNDS = 32;
    localparam logic [31:0] DELTA = 32'h9E37_79B9;
    localparam logic [63:0] DEC_SUM_WIDE = 64'(DELTA) * 64'(ROUNDS);
    localparam logic [31:0] DEC_SUM = DEC_SUM_WIDE[31:0];

    // block and padding
    localparam logic [3:0] BLOCK_BYTES = 4'd8;
    localparam logic [63:0] PAD_BLOCK = 64'h0808_0808_0808_0808;

    // register map
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_IV_LOW = 3'd4;
    localparam logic [2:0] REG_IV_HIGH = 3'd5;
    localparam logic [2:0] REG_DECRYPT = 3'd6;

    typedef logic [3:0][31:0] key_t;

    typedef struct packed {
        key_t        key;
        logic [63:0] iv;
        logic        decrypt;
    } cfg_t;

    // one slot of the round chain
    typedef struct packed {
        logic        vld;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        logic [63:0] mask;
        logic        last;
        logic        pad;
    } cell_t;

    function automatic logic [31:0] mix(input logic [31:0] v, input logic [31:0] s,
                                        input logic [31:0] k);
        mix = (((v << 4) ^ (v >> 5)) + v) ^ (s + k);
    endfunction

endpackage

@@ design/xcc_apb_regs.sv @@
module xcc_apb_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output xcc_pkg::cfg_t              cfg
);

    xcc_pkg::key_t key_reg;
    logic [63:0]   iv_reg;
    logic          decrypt_reg;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            iv_reg      <= '0;
            decrypt_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                xcc_pkg::REG_KEY0:    key_reg[0] <= pwdata;
                xcc_pkg::REG_KEY1:    key_reg[1] <= pwdata;
                xcc_pkg::REG_KEY2:    key_reg[2] <= pwdata;
                xcc_pkg::REG_KEY3:    key_reg[3] <= pwdata;
                xcc_pkg::REG_IV_LOW:  iv_reg[31:0] <= pwdata;
                xcc_pkg::REG_IV_HIGH: iv_reg[63:32] <= pwdata;
                xcc_pkg::REG_DECRYPT: decrypt_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            xcc_pkg::REG_KEY0:    prdata = key_reg[0];
            xcc_pkg::REG_KEY1:    prdata = key_reg[1];
            xcc_pkg::REG_KEY2:    prdata = key_reg[2];
            xcc_pkg::REG_KEY3:    prdata = key_reg[3];
            xcc_pkg::REG_IV_LOW:  prdata = iv_reg[31:0];
            xcc_pkg::REG_IV_HIGH: prdata = iv_reg[63:32];
            xcc_pkg::REG_DECRYPT: prdata = {31'd0, decrypt_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.key     = key_reg;
    assign cfg.iv      = iv_reg;
    assign cfg.decrypt = decrypt_reg;

endmodule

@@ design/xcc_round_cell.sv @@
module xcc_round_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 decrypt,
    input  xcc_pkg::key_t        key,
    input  xcc_pkg::cell_t       cell_in,
    output xcc_pkg::cell_t       cell_out
);

    logic [31:0] s_enc;
    logic [31:0] s_dec;
    logic [31:0] v0_enc;
    logic [31:0] v1_enc;
    logic [31:0] v0_dec;
    logic [31:0] v1_dec;
    logic        vld_reg;
    logic [31:0] v0_reg;
    logic [31:0] v0_next;
    logic [31:0] v1_reg;
    logic [31:0] v1_next;
    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic [63:0] mask_reg;
    logic        last_reg;
    logic        pad_reg;

    // one full round, two half-rounds
    always_comb
    begin
        s_enc  = cell_in.sum + xcc_pkg::DELTA;
        v0_enc = cell_in.v0 + xcc_pkg::mix(cell_in.v1, cell_in.sum, key[cell_in.sum[1:0]]);
        v1_enc = cell_in.v1 + xcc_pkg::mix(v0_enc, s_enc, key[s_enc[12:11]]);
        s_dec  = cell_in.sum - xcc_pkg::DELTA;
        v1_dec = cell_in.v1 - xcc_pkg::mix(cell_in.v0, cell_in.sum, key[cell_in.sum[12:11]]);
        v0_dec = cell_in.v0 - xcc_pkg::mix(v1_dec, s_dec, key[s_dec[1:0]]);
        v0_next  = decrypt ? v0_dec : v0_enc;
        v1_next  = decrypt ? v1_dec : v1_enc;
        sum_next = decrypt ? s_dec : s_enc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= cell_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v0_reg   <= v0_next;
            v1_reg   <= v1_next;
            sum_reg  <= sum_next;
            mask_reg <= cell_in.mask;
            last_reg <= cell_in.last;
            pad_reg  <= cell_in.pad;
        end
    end

    assign cell_out.vld  = vld_reg;
    assign cell_out.v0   = v0_reg;
    assign cell_out.v1   = v1_reg;
    assign cell_out.sum  = sum_reg;
    assign cell_out.mask = mask_reg;
    assign cell_out.last = last_reg;
    assign cell_out.pad  = pad_reg;

endmodule

@@ design/xtea_cbc_cipher.sv @@
// channel  handshake             payload                                             dir
// input    in_valid, in_stall    data_low/high, valid_bytes, first_block, last_block in
// output   out_valid, out_stall  result_low, result_high, result_last                out
// config   psel, penable, pready pwrite, paddr, pwdata, prdata (key, iv, mode)       in/out
//
// a block runs through a row of ROUNDS round cells, one round per cycle while the row advances, then an output register
// encrypt: the ciphertext feeds the next block, so a new item is taken only as the previous one leaves the row;
//   a full last block adds a padding block that follows straight on, entering the row as that block leaves it
// decrypt: chaining uses the incoming ciphertext, so an item may enter every cycle while the row advances
// reset clears the cell valids, the chaining vector, the busy flag and the output valid; data registers are not reset
// out_stall with a finished block waiting in the output register and another at the tail freezes the whole row

module xtea_cbc_cipher
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                data_low,
    input  logic [31:0]                data_high,
    input  logic [3:0]                 valid_bytes,
    input  logic                       first_block,
    input  logic                       last_block,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [31:0]                result_low,
    output logic [31:0]                result_high,
    output logic                       result_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    xcc_pkg::cfg_t  cfg;
    xcc_pkg::cell_t chain [xcc_pkg::ROUNDS+1];
    xcc_pkg::cell_t tail;

    logic [xcc_pkg::ROUNDS-1:0] vld_vec;

    logic        advance;
    logic        chain_exit;
    logic        enc_exit;
    logic        inject;
    logic        can_acc_enc;
    logic        in_acc;
    logic [63:0] ct;
    logic [63:0] blk;
    logic [63:0] padded;
    logic [63:0] base;
    logic [63:0] cv_eff;
    logic [3:0]  nvalid;
    logic [7:0]  pad_val;
    logic        full_last;

    logic [63:0] cv_reg;
    logic [63:0] cv_next;
    logic        busy_reg;
    logic        busy_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_data_reg;
    logic        out_last_reg;

    xcc_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // row of round cells, cell g hands its block to cell g+1
    for (genvar g = 0; g < xcc_pkg::ROUNDS; g++)
    begin : g_cell
        xcc_round_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .decrypt  (cfg.decrypt),
            .key      (cfg.key),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
        assign vld_vec[g] = chain[g+1].vld;
    end

    assign tail = chain[xcc_pkg::ROUNDS];
    assign ct   = {tail.v1, tail.v0};

    // the row moves unless a finished block has nowhere to go
    assign advance    = !(tail.vld && out_valid_reg && out_stall);
    assign chain_exit = tail.vld && advance;
    assign enc_exit   = chain_exit && !cfg.decrypt;
    assign inject     = enc_exit && tail.pad;

    // next encrypt item may start in the cycle the previous one leaves
    assign can_acc_enc = !busy_reg || (enc_exit && !tail.pad);
    assign in_stall    = !advance || (!cfg.decrypt && !can_acc_enc);
    assign in_acc      = in_valid && !in_stall;

    assign cv_eff = enc_exit ? ct : cv_reg;
    assign base   = first_block ? cfg.iv : cv_eff;
    assign blk    = {data_high, data_low};

    // pkcs7 style padding of a partial last block
    always_comb
    begin
        nvalid    = (valid_bytes > xcc_pkg::BLOCK_BYTES) ? xcc_pkg::BLOCK_BYTES : valid_bytes;
        pad_val   = {4'd0, xcc_pkg::BLOCK_BYTES - nvalid};
        full_last = last_block && (nvalid == xcc_pkg::BLOCK_BYTES);
        padded    = blk;
        for (int i = 0; i < 8; i++)
        begin
            if (last_block && (4'(i) >= nvalid))
            begin
                padded[8*i +: 8] = pad_val;
            end
        end
    end

    // head of the row: padding block, decrypt item or encrypt item
    always_comb
    begin
        chain[0].vld  = in_acc || inject;
        chain[0].sum  = '0;
        chain[0].mask = '0;
        chain[0].pad  = 1'b0;
        if (inject)
        begin
            {chain[0].v1, chain[0].v0} = xcc_pkg::PAD_BLOCK ^ ct;
            chain[0].last = 1'b1;
        end
        else if (cfg.decrypt)
        begin
            {chain[0].v1, chain[0].v0} = blk;
            chain[0].sum  = xcc_pkg::DEC_SUM;
            chain[0].mask = base;
            chain[0].last = last_block;
        end
        else
        begin
            {chain[0].v1, chain[0].v0} = padded ^ base;
            chain[0].last = last_block && !full_last;
            chain[0].pad  = full_last;
        end
    end

    always_comb
    begin
        cv_next = cv_reg;
        if (enc_exit)
        begin
            cv_next = ct;
        end
        else if (in_acc && cfg.decrypt)
        begin
            cv_next = blk;
        end

        busy_next = busy_reg;
        if (in_acc && !cfg.decrypt)
        begin
            busy_next = 1'b1;
        end
        else if (enc_exit && !tail.pad)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (chain_exit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg        <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cv_reg        <= cv_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_exit)
        begin
            out_data_reg <= cfg.decrypt ? (ct ^ tail.mask) : ct;
            out_last_reg <= tail.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_low  = out_data_reg[31:0];
    assign result_high = out_data_reg[63:32];
    assign result_last = out_last_reg;

    // encrypt keeps at most one block in the row
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.decrypt |-> ($countones(vld_vec) <= 1))
        else $error("more than one encrypt block in the round row");

    // padding block only follows an encrypt item still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        inject |-> (busy_reg && !in_acc))
        else $error("padding block injected outside an encrypt item");

    // a finished block held back by a stall stays at the tail
    assert property (@(posedge clk) disable iff (!rst_n)
        (tail.vld && out_valid_reg && out_stall) |=> (tail.vld && $stable(ct)))
        else $error("tail block lost while output stalled");

endmodule

@@ sim/tb_top.sv @@
// a directed script of items runs first, then random messages under random keys and ivs
// every accepted item goes through a cbc predictor in this file, and the results it
// yields wait in a queue until the block hands them out, oldest first

module tb_top;

    // run-time guard, several times the slowest correct run
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS = 215;

    // register setups used by the directed script
    typedef enum {
        SETUP_KEEP,
        SETUP_ONES_ENC,
        SETUP_MIX_DEC,
        SETUP_ZERO_DEC,
        SETUP_MIX_ENC
    } setup_e;

    // one row of the directed script
    typedef struct {
        setup_e      setup;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
    } script_row_t;

    // one output block as the predictor works it out
    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        last;
    } out_block_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [31:0]                 data_low;
    logic [31:0]                 data_high;
    logic [3:0]                  valid_bytes;
    logic                        first_block;
    logic                        last_block;
    logic                        out_valid;
    logic                        out_stall;
    logic [31:0]                 result_low;
    logic [31:0]                 result_high;
    logic                        result_last;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [xcc_pkg::ADDR_W-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // predictor's copy of the registers and of the chaining vector
    xcc_pkg::cfg_t               cipher_cfg;
    logic [63:0]                 chain_vec;

    out_block_t                  due_blocks[$];
    script_row_t                 script[$];
    out_block_t                  seen;
    int                          errors;
    int                          cycle_count;
    logic                        no_gaps;

    xtea_cbc_cipher dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_low    (data_low),
        .data_high   (data_high),
        .valid_bytes (valid_bytes),
        .first_block (first_block),
        .last_block  (last_block),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_low  (result_low),
        .result_high (result_high),
        .result_last (result_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 8 unit period
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // one xtea half-round mixing term
    function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] s,
                                              input logic [31:0] k);
        return (((v << 4) ^ (v >> 5)) + v) ^ (s + k);
    endfunction

    function automatic logic [63:0] xtea_encipher(input logic [63:0] blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] s;
        v0 = blk[31:0];
        v1 = blk[63:32];
        s = '0;
        for (int r = 0; r < xcc_pkg::ROUNDS; r++)
        begin
            v0 = v0 + round_mix(v1, s, cipher_cfg.key[s[1:0]]);
            s = s + xcc_pkg::DELTA;
            v1 = v1 + round_mix(v0, s, cipher_cfg.key[s[12:11]]);
        end
        return {v1, v0};
    endfunction

    function automatic logic [63:0] xtea_decipher(input logic [63:0] blk);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] s;
        v0 = blk[31:0];
        v1 = blk[63:32];
        // sum after all rounds, wrapped to 32 bits
        s = xcc_pkg::DEC_SUM;
        for (int r = 0; r < xcc_pkg::ROUNDS; r++)
        begin
            v1 = v1 - round_mix(v0, s, cipher_cfg.key[s[12:11]]);
            s = s - xcc_pkg::DELTA;
            v0 = v0 - round_mix(v1, s, cipher_cfg.key[s[1:0]]);
        end
        return {v1, v0};
    endfunction

    function automatic void queue_block(input logic [63:0] blk, input logic last);
        due_blocks.push_back('{lo: blk[31:0], hi: blk[63:32], last: last});
    endfunction

    // chain one block forward in encrypt mode
    function automatic void cbc_forward(input logic [63:0] plain, input logic last);
        chain_vec = xtea_encipher(plain ^ chain_vec);
        queue_block(chain_vec, last);
    endfunction

    // expected output blocks of one accepted item
    function automatic void cbc_predict(input logic [31:0] lo, input logic [31:0] hi,
                                        input logic [3:0] nbytes, input logic first,
                                        input logic last);
        logic [63:0] blk;
        logic [3:0]  kept;
        blk = {hi, lo};
        if (first)
            chain_vec = cipher_cfg.iv;
        if (cipher_cfg.decrypt)
        begin
            // incoming ciphertext chains, padding left in place
            queue_block(xtea_decipher(blk) ^ chain_vec, last);
            chain_vec = blk;
        end
        else if (!last)
            cbc_forward(blk, 1'b0);
        else
        begin
            kept = (nbytes > xcc_pkg::BLOCK_BYTES) ? xcc_pkg::BLOCK_BYTES : nbytes;
            if (kept == xcc_pkg::BLOCK_BYTES)
            begin
                // full last block: a whole block of padding follows
                cbc_forward(blk, 1'b0);
                cbc_forward(xcc_pkg::PAD_BLOCK, 1'b1);
            end
            else
            begin
                for (int i = 0; i < 8; i++)
                    if (i >= kept)
                        blk[8*i +: 8] = {4'd0, xcc_pkg::BLOCK_BYTES - kept};
                cbc_forward(blk, 1'b1);
            end
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    // apb write with read-back, predictor copy follows the write
    task automatic cfg_write(input logic [2:0] code, input logic [31:0] value);
        logic [31:0] mask;
        mask = (code == xcc_pkg::REG_DECRYPT) ? 32'h1 : 32'hFFFF_FFFF;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (code)
            xcc_pkg::REG_KEY0:    cipher_cfg.key[0] = value;
            xcc_pkg::REG_KEY1:    cipher_cfg.key[1] = value;
            xcc_pkg::REG_KEY2:    cipher_cfg.key[2] = value;
            xcc_pkg::REG_KEY3:    cipher_cfg.key[3] = value;
            xcc_pkg::REG_IV_LOW:  cipher_cfg.iv[31:0] = value;
            xcc_pkg::REG_IV_HIGH: cipher_cfg.iv[63:32] = value;
            xcc_pkg::REG_DECRYPT: cipher_cfg.decrypt = value[0];
            default:              ;
        endcase
        // read it back
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & mask) != (value & mask))
        begin
            $display("%0t: register %0d reads %h, expected %h", $time, code,
                     prdata & mask, value & mask);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // hold the sender until every expected block has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_blocks.size() != 0)
            @(posedge clk);
    endtask

    // registers are only touched with the block idle
    task automatic apply_setup(input xcc_pkg::cfg_t c);
        wait_drained();
        cfg_write(xcc_pkg::REG_KEY0, c.key[0]);
        cfg_write(xcc_pkg::REG_KEY1, c.key[1]);
        cfg_write(xcc_pkg::REG_KEY2, c.key[2]);
        cfg_write(xcc_pkg::REG_KEY3, c.key[3]);
        cfg_write(xcc_pkg::REG_IV_LOW, c.iv[31:0]);
        cfg_write(xcc_pkg::REG_IV_HIGH, c.iv[63:32]);
        cfg_write(xcc_pkg::REG_DECRYPT, {31'd0, c.decrypt});
    endtask

    // offer one item, predict it once it is taken
    task automatic send_block(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [3:0] nbytes, input logic first, input logic last);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_low    <= lo;
        data_high   <= hi;
        valid_bytes <= nbytes;
        first_block <= first;
        last_block  <= last;
        do @(posedge clk); while (in_stall);
        cbc_predict(lo, hi, nbytes, first, last);
    endtask

    // receiver stalls now and then
    always @(negedge clk)
        out_stall <= !no_gaps && ($urandom_range(99) < 6);

    // ---------------------------------------------------------------- checker

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_blocks.size() == 0)
            begin
                $display("%0t: block %h_%h last %b with none expected", $time,
                         result_high, result_low, result_last);
                errors++;
            end
            else
            begin
                seen = due_blocks.pop_front();
                if (result_low !== seen.lo)
                begin
                    $display("%0t: result_low expected %h, got %h", $time, seen.lo, result_low);
                    errors++;
                end
                if (result_high !== seen.hi)
                begin
                    $display("%0t: result_high expected %h, got %h", $time, seen.hi,
                             result_high);
                    errors++;
                end
                if (result_last !== seen.last)
                begin
                    $display("%0t: result_last expected %b, got %b", $time, seen.last,
                             result_last);
                    errors++;
                end
            end
        end
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void add_row(input setup_e setup, input logic [31:0] lo,
                                    input logic [31:0] hi, input logic [3:0] nbytes,
                                    input logic first, input logic last);
        script.push_back('{setup: setup, lo: lo, hi: hi, nbytes: nbytes, first: first,
                           last: last});
    endfunction

    // mostly random words, now and then an extreme
    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic xcc_pkg::cfg_t setup_values(input setup_e setup);
        xcc_pkg::cfg_t c;
        c = '0;
        case (setup)
            SETUP_ONES_ENC:
            begin
                c.key = '1;
                c.iv  = '1;
            end
            SETUP_MIX_DEC, SETUP_MIX_ENC:
            begin
                c.key[0]  = 32'h0302_0100;
                c.key[1]  = 32'h0706_0504;
                c.key[2]  = 32'h0B0A_0908;
                c.key[3]  = 32'h0F0E_0D0C;
                c.iv      = 64'h89AB_CDEF_0123_4567;
                c.decrypt = (setup == SETUP_MIX_DEC);
            end
            SETUP_ZERO_DEC:
                c.decrypt = 1'b1;
            default: ;
        endcase
        return c;
    endfunction

    function automatic xcc_pkg::cfg_t random_setup(input logic decrypt);
        xcc_pkg::cfg_t c;
        for (int i = 0; i < 4; i++)
            c.key[i] = rand_word();
        c.iv      = {rand_word(), rand_word()};
        c.decrypt = decrypt;
        return c;
    endfunction

    function automatic void build_script();
        // registers still at reset: zero key, encrypt, chain from zero with no first block
        add_row(SETUP_KEEP,     32'h0000_0000, 32'h0000_0000, 4'd0,  1'b0, 1'b0);
        add_row(SETUP_KEEP,     32'h1234_5678, 32'h9ABC_DEF0, 4'd3,  1'b0, 1'b1);
        add_row(SETUP_KEEP,     32'hDEAD_BEEF, 32'hCAFE_F00D, 4'd8,  1'b1, 1'b1);
        // all-ones key and iv, partial last blocks of 0, 1, 2, 4 and 7 bytes, saturation above eight
        add_row(SETUP_ONES_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b0);
        add_row(SETUP_KEEP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  1'b0, 1'b1);
        add_row(SETUP_KEEP,     32'hA5A5_A5A5, 32'h5A5A_5A5A, 4'd15, 1'b1, 1'b1);
        add_row(SETUP_KEEP,     32'h0706_0504, 32'h0302_0100, 4'd7,  1'b1, 1'b1);
        add_row(SETUP_KEEP,     32'h1111_1111, 32'h2222_2222, 4'd1,  1'b1, 1'b1);
        add_row(SETUP_KEEP,     32'h7654_3210, 32'hFEDC_BA98, 4'd4,  1'b1, 1'b1);
        add_row(SETUP_KEEP,     32'h0000_0000, 32'h0000_0000, 4'd9,  1'b1, 1'b1);
        add_row(SETUP_KEEP,     32'h8000_0001, 32'h0000_00FF, 4'd2,  1'b1, 1'b1);
        // decrypt: valid_bytes ignored, last copied through
        add_row(SETUP_MIX_DEC,  32'h0000_0000, 32'h0000_0000, 4'd0,  1'b1, 1'b0);
        add_row(SETUP_KEEP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd5,  1'b0, 1'b0);
        add_row(SETUP_KEEP,     32'h3C3C_3C3C, 32'hC3C3_C3C3, 4'd3,  1'b0, 1'b1);
        add_row(SETUP_KEEP,     32'h0123_4567, 32'h89AB_CDEF, 4'd8,  1'b1, 1'b1);
        add_row(SETUP_ZERO_DEC, 32'h0000_0000, 32'h0000_0000, 4'd6,  1'b1, 1'b0);
        add_row(SETUP_KEEP,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b0, 1'b1);
        // back to encrypt under the mixed key
        add_row(SETUP_MIX_ENC,  32'h0302_0100, 32'h0706_0504, 4'd8,  1'b1, 1'b0);
        add_row(SETUP_KEEP,     32'hAAAA_5555, 32'h5555_AAAA, 4'd6,  1'b0, 1'b1);
        add_row(SETUP_KEEP,     32'h0F0F_0F0F, 32'hF0F0_F0F0, 4'd5,  1'b0, 1'b1);
        add_row(SETUP_KEEP,     32'h1357_9BDF, 32'h2468_ACE0, 4'd8,  1'b0, 1'b1);
    endfunction

    initial
    begin
        int          sent;
        int          msg_len;
        logic        is_last;
        logic        paused;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_low    = '0;
        data_high   = '0;
        valid_bytes = '0;
        first_block = 1'b0;
        last_block  = 1'b0;
        out_stall   = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cipher_cfg  = '0;
        chain_vec   = '0;
        errors      = 0;
        cycle_count = 0;
        no_gaps     = 1'b0;
        paused      = 1'b0;
        build_script();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed script
        foreach (script[i])
        begin
            if (script[i].setup != SETUP_KEEP)
                apply_setup(setup_values(script[i].setup));
            send_block(script[i].lo, script[i].hi, script[i].nbytes, script[i].first,
                       script[i].last);
        end

        // random phases, encrypt and decrypt in turn; phase 2 runs with no gaps at all
        for (int ph = 0; ph < 6; ph++)
        begin
            apply_setup(random_setup(ph % 2 == 1));
            no_gaps = (ph == 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // one full stop mid-phase until the pipe is empty
                if (ph == 3 && sent >= 100 && !paused)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(9) == 0)
                begin
                    // noise: any flags, any byte count
                    send_block(rand_word(), rand_word(), 4'($urandom_range(15)),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
                    sent++;
                end
                else
                begin
                    // well-formed message of a few blocks
                    msg_len = $urandom_range(1, 6);
                    for (int j = 0; j < msg_len; j++)
                    begin
                        is_last = (j == msg_len - 1);
                        send_block(rand_word(), rand_word(),
                                   is_last ? 4'($urandom_range(8)) : 4'($urandom_range(15)),
                                   j == 0, is_last);
                        sent++;
                    end
                end
            end
        end

        // let everything drain, then a little longer for stray blocks
        no_gaps = 1'b0;
        wait_drained();
        repeat (2 * xcc_pkg::ROUNDS + 8) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/xcc_pkg.sv
design/xcc_apb_regs.sv
design/xcc_round_cell.sv
design/xtea_cbc_cipher.sv
sim/tb_top.sv
